// ----- design/dnsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dnsp_pkg
// Shared types and constants for the DNS answer record parser.
// ----------------------------------------------------------------------------
package dnsp_pkg;

    localparam int RECEIVE_LIMIT_DEFAULT = 1000;
    localparam int POS_W                 = 11;
    localparam int QUEUE_DEPTH           = 4;
    localparam int CFG_IDX_W             = 2;
    localparam int CFG_DATA_W            = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_KIND   = 2'd1;

    // record_kind values
    localparam logic MODE_A   = 1'b0;
    localparam logic MODE_TXT = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ADDR   = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_RCODE = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // header layout, stream offsets including the length prefix
    localparam logic [POS_W-1:0] POS_FLAGS    = 11'd5;
    localparam logic [POS_W-1:0] POS_ANCNT_HI = 11'd8;
    localparam logic [POS_W-1:0] POS_ANCNT_LO = 11'd9;
    localparam logic [POS_W-1:0] POS_HDR_END  = 11'd10;

    localparam logic [15:0] TYPE_A     = 16'h0001;
    localparam logic [15:0] TYPE_TXT   = 16'h0010;
    localparam logic [15:0] FIXED_SKIP = 16'd6;
    localparam logic [15:0] A_RDLEN    = 16'd4;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_NAME,
        PH_LABEL,
        PH_PTR,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_FIXED,
        PH_RDLEN_HI,
        PH_RDLEN_LO,
        PH_ADDR,
        PH_TXT_LEN,
        PH_TXT_CHAR,
        PH_RDSKIP,
        PH_DONE
    } dnsp_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_reply;
    } dnsp_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  text_byte;
        logic        text_last;
        logic [1:0]  status;
        logic [3:0]  rcode;
        logic        last_of_run;
    } dnsp_out_t;

    // words produced by one byte: an optional record word, then an optional status
    typedef struct packed {
        logic      rec_valid;
        logic      stat_valid;
        dnsp_out_t rec;
        dnsp_out_t stat;
    } dnsp_emit_t;

endpackage

// ----- design/dns_answer_record_parser_unit.sv -----
// ----------------------------------------------------------------------------
// dns_answer_record_parser_unit
// Parses a DNS-over-TCP reply byte stream into A addresses or TXT characters
// and a final status word.
// ----------------------------------------------------------------------------
// One reply byte is taken per cycle unless stalled, starting at the 2-byte
// length prefix; the field state machine handles each byte in the cycle it is
// accepted. Result words leave through a 4-word queue at one word per cycle
// unless stalled, so a byte's record and status words leave one after the
// other. byte_stall rises while the queue holds three or more words, which
// happens only when the result side stalls. With the queue empty, a byte's
// first result word is valid in the next cycle. Configuration is taken at any
// time (cfg_ready is always high) but should only change between replies.
module dns_answer_record_parser_unit
    import dnsp_pkg::*;
#(
    parameter int RECEIVE_LIMIT = RECEIVE_LIMIT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  dnsp_in_t              byte_word,
    output logic                  result_valid,
    input  logic                  result_stall,
    output dnsp_out_t             result_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [CFG_DATA_W-1:0] answer_offset_reg;
    logic                  record_kind_reg;
    logic                  step;
    logic                  pop;
    dnsp_emit_t            emit;
    logic [LVL_W-1:0]      level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_offset_reg <= 10'd19;
            record_kind_reg   <= MODE_A;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ANSWER_OFFSET: answer_offset_reg <= cfg_data;
                CFG_RECORD_KIND:   record_kind_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // room for two words must be left before a byte is taken
    assign byte_stall   = level > LVL_W'(QUEUE_DEPTH - 2);
    assign step         = byte_valid && !byte_stall;
    assign result_valid = level != '0;
    assign pop          = result_valid && !result_stall;

    dnsp_parser #(
        .RECEIVE_LIMIT (RECEIVE_LIMIT)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .word          (byte_word),
        .answer_offset (answer_offset_reg),
        .record_kind   (record_kind_reg),
        .emit          (emit)
    );

    dnsp_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .emit  (emit),
        .pop   (pop),
        .head  (result_word),
        .level (level)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LVL_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (step && byte_word.end_of_reply) |=> result_valid)
        else $error("status word missing after end of reply");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!step && !result_valid) |=> !result_valid)
        else $error("result word without an accepted byte");

    a_one_status: assert property (@(posedge clk) disable iff (!rst_n)
        emit.stat_valid |-> (emit.stat.kind == KIND_STATUS && emit.stat.last_of_run))
        else $error("status word malformed");

endmodule

// ----- design/dnsp_parser.sv -----
// ----------------------------------------------------------------------------
// dnsp_parser
// Per-byte field state machine: header, owner name, fixed fields, rdata.
// ----------------------------------------------------------------------------
module dnsp_parser
    import dnsp_pkg::*;
#(
    parameter int RECEIVE_LIMIT = RECEIVE_LIMIT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  dnsp_in_t              word,
    input  logic [CFG_DATA_W-1:0] answer_offset,
    input  logic                  record_kind,
    output dnsp_emit_t            emit
);

    localparam logic [POS_W-1:0] LIMIT = POS_W'(RECEIVE_LIMIT);

    logic [POS_W-1:0] pos_reg,     pos_next;
    dnsp_phase_t      phase_reg,   phase_next;
    logic [3:0]       rcode_reg,   rcode_next;
    logic [15:0]      answers_reg, answers_next;
    logic [15:0]      skip_reg,    skip_next;
    logic [15:0]      rtype_reg,   rtype_next;
    logic [15:0]      rdlen_reg,   rdlen_next;
    logic [31:0]      addr_reg,    addr_next;
    logic [7:0]       text_reg,    text_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_HEADER;
            rcode_reg   <= '0;
            answers_reg <= '0;
            skip_reg    <= '0;
            rtype_reg   <= '0;
            rdlen_reg   <= '0;
            addr_reg    <= '0;
            text_reg    <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            rcode_reg   <= rcode_next;
            answers_reg <= answers_next;
            skip_reg    <= skip_next;
            rtype_reg   <= rtype_next;
            rdlen_reg   <= rdlen_next;
            addr_reg    <= addr_next;
            text_reg    <= text_next;
        end
    end

    always_comb
    begin
        logic [7:0]       b;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] offset_ext;
        dnsp_phase_t      ph;
        logic             go;
        logic             done;

        b            = word.data_byte;
        p            = pos_reg;
        offset_ext   = {1'b0, answer_offset};
        ph           = phase_reg;
        go           = 1'b0;
        done         = 1'b0;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        rcode_next   = rcode_reg;
        answers_next = answers_reg;
        skip_next    = skip_reg;
        rtype_next   = rtype_reg;
        rdlen_next   = rdlen_reg;
        addr_next    = addr_reg;
        text_next    = text_reg;
        emit         = '0;

        if (step && (pos_reg < LIMIT))
        begin
            pos_next = pos_reg + 1'b1;
            if (p == POS_FLAGS)    rcode_next = b[3:0];
            if (p == POS_ANCNT_HI) answers_next[15:8] = b;
            if (p == POS_ANCNT_LO) answers_next[7:0] = b;

            go = 1'b1;
            if (phase_reg == PH_HEADER)
            begin
                if (p < POS_HDR_END || p < offset_ext)
                    go = 1'b0;
                else if (rcode_next != 4'd0 || answers_next == 16'd0)
                begin
                    phase_next = PH_DONE;
                    go         = 1'b0;
                end
                else
                    ph = PH_NAME;   // first answer byte is parsed right away
            end

            if (go)
            begin
                unique case (ph)
                    PH_NAME:
                    begin
                        if (b == 8'd0)
                            phase_next = PH_TYPE_HI;
                        else if (b[7:6] == 2'b11)
                            phase_next = PH_PTR;
                        else
                        begin
                            skip_next  = {8'd0, b};
                            phase_next = PH_LABEL;
                        end
                    end
                    PH_LABEL:
                    begin
                        skip_next = skip_reg - 1'b1;
                        if (skip_next == 16'd0) phase_next = PH_NAME;
                    end
                    PH_PTR:
                        phase_next = PH_TYPE_HI;
                    PH_TYPE_HI:
                    begin
                        rtype_next = {b, 8'd0};
                        phase_next = PH_TYPE_LO;
                    end
                    PH_TYPE_LO:
                    begin
                        rtype_next = {rtype_reg[15:8], b};
                        skip_next  = FIXED_SKIP;
                        phase_next = PH_FIXED;
                    end
                    PH_FIXED:
                    begin
                        skip_next = skip_reg - 1'b1;
                        if (skip_next == 16'd0) phase_next = PH_RDLEN_HI;
                    end
                    PH_RDLEN_HI:
                    begin
                        rdlen_next = {b, 8'd0};
                        phase_next = PH_RDLEN_LO;
                    end
                    PH_RDLEN_LO:
                    begin
                        rdlen_next = {rdlen_reg[15:8], b};
                        skip_next  = rdlen_next;
                        if (rdlen_next == 16'd0)
                            done = 1'b1;
                        else if (record_kind == MODE_A && rtype_reg == TYPE_A
                                 && rdlen_next == A_RDLEN)
                        begin
                            addr_next  = '0;
                            phase_next = PH_ADDR;
                        end
                        else if (record_kind == MODE_TXT && rtype_reg == TYPE_TXT)
                            phase_next = PH_TXT_LEN;
                        else
                            phase_next = PH_RDSKIP;
                    end
                    PH_ADDR:
                    begin
                        addr_next = {addr_reg[23:0], b};
                        skip_next = skip_reg - 1'b1;
                        if (skip_next == 16'd0)
                        begin
                            emit.rec_valid   = 1'b1;
                            emit.rec.kind    = KIND_ADDR;
                            emit.rec.address = addr_next;
                            done             = 1'b1;
                        end
                    end
                    PH_TXT_LEN:
                    begin
                        text_next = b;
                        skip_next = skip_reg - 1'b1;
                        if (skip_next == 16'd0)
                            done = 1'b1;
                        else
                            phase_next = (b == 8'd0) ? PH_RDSKIP : PH_TXT_CHAR;
                    end
                    PH_TXT_CHAR:
                    begin
                        text_next           = text_reg - 1'b1;
                        skip_next           = skip_reg - 1'b1;
                        emit.rec_valid      = 1'b1;
                        emit.rec.kind       = KIND_TEXT;
                        emit.rec.text_byte  = b;
                        emit.rec.text_last  = (text_next == 8'd0) || (skip_next == 16'd0);
                        if (skip_next == 16'd0)
                            done = 1'b1;
                        else if (text_next == 8'd0)
                            phase_next = PH_RDSKIP;
                    end
                    PH_RDSKIP:
                    begin
                        skip_next = skip_reg - 1'b1;
                        if (skip_next == 16'd0) done = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (done)
            begin
                answers_next = answers_next - 1'b1;
                phase_next   = (answers_next == 16'd0) ? PH_DONE : PH_NAME;
            end
        end

        if (step && word.end_of_reply)
        begin
            emit.rec.last_of_run = 1'b0;
            emit.stat_valid      = 1'b1;
            emit.stat.kind       = KIND_STATUS;
            emit.stat.rcode      = rcode_next;
            emit.stat.last_of_run = 1'b1;
            if (pos_next < offset_ext)
                emit.stat.status = ST_SHORT;
            else if (rcode_next != 4'd0)
                emit.stat.status = ST_RCODE;
            else if (answers_next != 16'd0)
                emit.stat.status = ST_TRUNC;
            else
                emit.stat.status = ST_OK;

            pos_next     = '0;
            phase_next   = PH_HEADER;
            rcode_next   = '0;
            answers_next = '0;
            skip_next    = '0;
            rtype_next   = '0;
            rdlen_next   = '0;
            addr_next    = '0;
            text_next    = '0;
        end
        else
            emit.rec.last_of_run = emit.rec_valid;
    end

endmodule

// ----- design/dnsp_out_queue.sv -----
// ----------------------------------------------------------------------------
// dnsp_out_queue
// Short shift queue of result words; takes up to two words per cycle.
// ----------------------------------------------------------------------------
module dnsp_out_queue
    import dnsp_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  dnsp_emit_t                       emit,
    input  logic                             pop,
    output dnsp_out_t                        head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] level
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    dnsp_out_t          entry_reg [QUEUE_DEPTH];
    dnsp_out_t          entry_next [QUEUE_DEPTH];
    logic [LVL_W-1:0]   level_reg, level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else
            level_reg <= level_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            entry_reg[i] <= entry_next[i];
    end

    always_comb
    begin
        logic [LVL_W-1:0] lvl;
        logic             one;
        logic             two;
        dnsp_out_t        first;

        lvl   = level_reg;
        one   = emit.rec_valid || emit.stat_valid;
        two   = emit.rec_valid && emit.stat_valid;
        first = emit.rec_valid ? emit.rec : emit.stat;

        for (int i = 0; i < QUEUE_DEPTH; i++)
            entry_next[i] = entry_reg[i];

        if (pop && level_reg != '0)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                entry_next[i] = entry_reg[i + 1];
            lvl = level_reg - 1'b1;
        end

        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (one && LVL_W'(i) == lvl)
                entry_next[i] = first;
            if (two && LVL_W'(i) == lvl + 1'b1)
                entry_next[i] = emit.stat;
        end

        level_next = lvl + LVL_W'(one) + LVL_W'(two);
    end

    assign head  = entry_reg[0];
    assign level = level_reg;

endmodule

// ----- tb/dns_answer_record_parser_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_answer_record_parser_unit_checker
// Watches the byte, result and register channels of the reply parser, runs its
// own model of the field walker on every accepted byte and compares each
// accepted result word with the oldest predicted word.
// ----------------------------------------------------------------------------
module dns_answer_record_parser_unit_checker
    import dnsp_pkg::*;
#(
    parameter int RECEIVE_LIMIT = RECEIVE_LIMIT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic                  byte_stall,
    input  dnsp_in_t              byte_word,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  dnsp_out_t             result_word,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam logic [CFG_DATA_W-1:0] OFFSET_AT_RESET = 10'd19;

    logic [CFG_DATA_W-1:0] offset_cfg;
    logic                  kind_cfg;

    logic [POS_W-1:0] position;
    dnsp_phase_t      phase;
    logic [3:0]       rcode_seen;
    logic [15:0]      answers_left;
    logic [15:0]      skip_left;
    logic [15:0]      rec_type;
    logic [15:0]      rd_len;
    logic [31:0]      addr_acc;
    logic [7:0]       text_left;

    dnsp_out_t predicted_words[$];
    dnsp_out_t want;

    task clear_reply();
        position     = '0;
        phase        = PH_HEADER;
        rcode_seen   = '0;
        answers_left = '0;
        skip_left    = '0;
        rec_type     = '0;
        rd_len       = '0;
        addr_acc     = '0;
        text_left    = '0;
    endtask

    task close_record();
        answers_left = answers_left - 16'd1;
        if (answers_left == 16'd0)
            phase = PH_DONE;
        else
            phase = PH_NAME;
    endtask

    task queue_word(input dnsp_out_t w);
        predicted_words = {predicted_words, w};
    endtask

    task predict_reply_byte(input dnsp_in_t w);
        logic [POS_W-1:0] p;
        logic [7:0]       b;
        logic             parse_on;
        int               made;
        dnsp_out_t        word;
        b = w.data_byte;
        made = 0;
        // bytes past the receive limit are dropped, but their end flag still counts
        if (position < RECEIVE_LIMIT)
        begin
            p = position;
            position = position + 1'b1;
            if (p == POS_FLAGS)
                rcode_seen = b[3:0];
            if (p == POS_ANCNT_HI)
                answers_left[15:8] = b;
            if (p == POS_ANCNT_LO)
                answers_left[7:0] = b;
            parse_on = 1'b1;
            if (phase == PH_HEADER)
            begin
                if (p < POS_HDR_END || p < offset_cfg)
                    parse_on = 1'b0;
                else if (rcode_seen != 4'd0 || answers_left == 16'd0)
                begin
                    phase = PH_DONE;
                    parse_on = 1'b0;
                end
                else
                    phase = PH_NAME;
            end
            if (parse_on)
            begin
                case (phase)
                    PH_NAME:
                    begin
                        if (b == 8'd0)
                            phase = PH_TYPE_HI;
                        else if (b[7:6] == 2'b11)
                            phase = PH_PTR;
                        else
                        begin
                            // reserved top bits 01/10 count as a plain length
                            skip_left = {8'd0, b};
                            phase = PH_LABEL;
                        end
                    end
                    PH_LABEL:
                    begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0)
                            phase = PH_NAME;
                    end
                    PH_PTR:
                        phase = PH_TYPE_HI;
                    PH_TYPE_HI:
                    begin
                        rec_type = {b, 8'd0};
                        phase = PH_TYPE_LO;
                    end
                    PH_TYPE_LO:
                    begin
                        rec_type[7:0] = b;
                        skip_left = FIXED_SKIP;
                        phase = PH_FIXED;
                    end
                    PH_FIXED:
                    begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0)
                            phase = PH_RDLEN_HI;
                    end
                    PH_RDLEN_HI:
                    begin
                        rd_len = {b, 8'd0};
                        phase = PH_RDLEN_LO;
                    end
                    PH_RDLEN_LO:
                    begin
                        rd_len[7:0] = b;
                        skip_left = rd_len;
                        if (rd_len == 16'd0)
                            close_record();
                        else if (kind_cfg == MODE_A && rec_type == TYPE_A && rd_len == A_RDLEN)
                        begin
                            addr_acc = '0;
                            phase = PH_ADDR;
                        end
                        else if (kind_cfg == MODE_TXT && rec_type == TYPE_TXT)
                            phase = PH_TXT_LEN;
                        else
                            phase = PH_RDSKIP;
                    end
                    PH_ADDR:
                    begin
                        addr_acc = {addr_acc[23:0], b};
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0)
                        begin
                            word = '0;
                            word.kind = KIND_ADDR;
                            word.address = addr_acc;
                            queue_word(word);
                            made++;
                            close_record();
                        end
                    end
                    PH_TXT_LEN:
                    begin
                        text_left = b;
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0)
                            close_record();
                        else if (text_left == 8'd0)
                            phase = PH_RDSKIP;
                        else
                            phase = PH_TXT_CHAR;
                    end
                    PH_TXT_CHAR:
                    begin
                        text_left = text_left - 8'd1;
                        skip_left = skip_left - 16'd1;
                        word = '0;
                        word.kind = KIND_TEXT;
                        word.text_byte = b;
                        word.text_last = (text_left == 8'd0 || skip_left == 16'd0);
                        queue_word(word);
                        made++;
                        if (skip_left == 16'd0)
                            close_record();
                        else if (text_left == 8'd0)
                            phase = PH_RDSKIP;
                    end
                    PH_RDSKIP:
                    begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0)
                            close_record();
                    end
                    default:
                        ;
                endcase
            end
        end
        if (w.end_of_reply)
        begin
            word = '0;
            word.kind = KIND_STATUS;
            word.rcode = rcode_seen;
            if (position < offset_cfg)
                word.status = ST_SHORT;
            else if (rcode_seen != 4'd0)
                word.status = ST_RCODE;
            else if (answers_left != 16'd0)
                word.status = ST_TRUNC;
            else
                word.status = ST_OK;
            queue_word(word);
            made++;
            clear_reply();
        end
        if (made > 0)
            predicted_words[predicted_words.size() - 1].last_of_run = 1'b1;
    endtask

    task check_field(input string label, input logic [31:0] exp_val, input logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, label, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_cfg = OFFSET_AT_RESET;
            kind_cfg   = MODE_A;
            clear_reply();
            predicted_words.delete();
            pending    = 0;
        end
        else
        begin
            // results first: a word leaving now was predicted on an earlier edge
            if (result_valid && !result_stall)
            begin
                if (predicted_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word 0x%0h arrived, expected no word",
                             $time, result_word);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    check_field("kind", want.kind, result_word.kind);
                    check_field("address", want.address, result_word.address);
                    check_field("text_byte", want.text_byte, result_word.text_byte);
                    check_field("text_last", want.text_last, result_word.text_last);
                    check_field("status", want.status, result_word.status);
                    check_field("rcode", want.rcode, result_word.rcode);
                    check_field("last_of_run", want.last_of_run, result_word.last_of_run);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ANSWER_OFFSET)
                    offset_cfg = cfg_data;
                else if (cfg_index == CFG_RECORD_KIND)
                    kind_cfg = cfg_data[0];
            end
            if (byte_valid && !byte_stall)
                predict_reply_byte(byte_word);
            pending = predicted_words.size();
        end
    end

endmodule

// ----- tb/dns_answer_record_parser_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_answer_record_parser_unit_test
// Feeds DNS-over-TCP replies into the answer record parser: directed replies
// for header, name, record and limit corner cases, then random well-formed,
// cut and noise replies under changing register settings and random gaps on
// both channels. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module dns_answer_record_parser_unit_test;
    import dnsp_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int TOTAL_BYTES   = 1850;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_DATA_W-1:0] OFFSET_AT_RESET = 10'd19;

    typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY} pace_t;
    typedef enum int {
        NAME_ROOT,
        NAME_POINTER,
        NAME_LABELS,
        NAME_LABELS_POINTER,
        NAME_WIDE_LOW,
        NAME_WIDE_HIGH
    } name_form_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  byte_valid;
    logic                  byte_stall;
    dnsp_in_t              byte_word;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    dnsp_out_t             result_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    logic [7:0]            frame[$];
    logic [CFG_DATA_W-1:0] offset_now = OFFSET_AT_RESET;
    pace_t                 byte_pace = PACE_FREE;
    pace_t                 result_pace = PACE_FREE;
    int                    pace_left = 0;
    int                    stall_left = 0;
    int                    cycle_count = 0;
    int                    bytes_sent = 0;

    dns_answer_record_parser_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    dns_answer_record_parser_unit_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dns_answer_record_parser_unit_test failed");
            $finish;
        end
    end

    // result side back-pressure: free, light and heavy stretches
    always @(negedge clk)
    begin
        if (pace_left == 0)
        begin
            pace_left = $urandom_range(64, 512);
            result_pace = pace_t'($urandom_range(0, 2));
        end
        else
            pace_left--;
        if (stall_left > 0)
            stall_left--;
        else if (result_pace == PACE_LIGHT && $urandom_range(0, 99) < 10)
            stall_left = $urandom_range(1, 2);
        else if (result_pace == PACE_HEAVY && $urandom_range(0, 99) < 30)
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(1, 4);
        result_stall <= (stall_left > 0);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (byte_pace == PACE_FREE)
            return 0;
        if (byte_pace == PACE_LIGHT)
            return (roll < 85) ? 0 : $urandom_range(1, 2);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_offset();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(19, 40);
        if (roll < 80)
            return $urandom_range(0, 18);
        if (roll < 97)
            return $urandom_range(41, 120);
        return $urandom_range(151, 1023);
    endfunction

    // entered just after the edge that took the previous word
    task send_byte(input logic [7:0] b, input logic eor);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_word.data_byte <= b;
        byte_word.end_of_reply <= eor;
        do @(posedge clk); while (byte_stall);
        bytes_sent++;
    endtask

    task send_frame();
        byte_pace = pace_t'($urandom_range(0, 2));
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    task wait_idle();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task set_config(input logic [CFG_DATA_W-1:0] offset, input logic kind);
        logic [CFG_DATA_W-2:0] junk;
        junk = $urandom;
        wait_idle();
        write_reg(CFG_ANSWER_OFFSET, offset);
        // upper bits of the kind register are don't-care
        write_reg(CFG_RECORD_KIND, {junk, kind});
        offset_now = offset;
    endtask

    task append_byte(input logic [7:0] b);
        frame = {frame, b};
    endtask

    task push_random(input int count);
        repeat (count) append_byte(8'($urandom_range(0, 255)));
    endtask

    // header plus filler up to where the answers begin
    task start_frame(input logic [3:0] rc, input logic [15:0] count);
        int         first;
        logic [3:0] upper;
        upper = $urandom;
        first = (offset_now < POS_HDR_END) ? POS_HDR_END : offset_now;
        frame.delete();
        push_random(5);
        append_byte({upper, rc});
        push_random(2);
        append_byte(count[15:8]);
        append_byte(count[7:0]);
        while (frame.size() < first)
            append_byte(8'($urandom_range(0, 255)));
    endtask

    task add_label(input int len);
        append_byte(len[7:0]);
        push_random(len);
    endtask

    task add_pointer();
        logic [5:0] low6;
        low6 = $urandom;
        append_byte({2'b11, low6});
        push_random(1);
    endtask

    task add_name(input name_form_t form);
        int labels;
        labels = $urandom_range(1, 3);
        case (form)
            NAME_ROOT:
                append_byte(8'h00);
            NAME_POINTER:
                add_pointer();
            NAME_LABELS:
            begin
                repeat (labels) add_label($urandom_range(1, 10));
                append_byte(8'h00);
            end
            NAME_LABELS_POINTER:
            begin
                repeat (labels) add_label($urandom_range(1, 10));
                add_pointer();
            end
            NAME_WIDE_LOW:
            begin
                add_label(8'h40 + $urandom_range(0, 7));
                append_byte(8'h00);
            end
            default:
            begin
                add_label(8'h80 + $urandom_range(0, 7));
                append_byte(8'h00);
            end
        endcase
    endtask

    task add_record(input logic [15:0] rtype, input logic [15:0] rdlen);
        append_byte(rtype[15:8]);
        append_byte(rtype[7:0]);
        push_random(6);
        append_byte(rdlen[15:8]);
        append_byte(rdlen[7:0]);
        push_random(rdlen);
    endtask

    task add_text_record(input logic [15:0] rdlen, input logic [7:0] str_len);
        add_record(TYPE_TXT, rdlen);
        if (rdlen != 16'd0)
            frame[frame.size() - rdlen] = str_len;
    endtask

    task random_record();
        int         roll;
        int         form_roll;
        logic [7:0] str_len;
        roll = $urandom_range(0, 99);
        form_roll = $urandom_range(0, 99);
        if (form_roll < 25)
            add_name(NAME_POINTER);
        else if (form_roll < 55)
            add_name(NAME_LABELS);
        else if (form_roll < 80)
            add_name(NAME_LABELS_POINTER);
        else if (form_roll < 95)
            add_name(NAME_ROOT);
        else if (form_roll < 98)
            add_name(NAME_WIDE_LOW);
        else
            add_name(NAME_WIDE_HIGH);
        if (roll < 35)
            add_record(TYPE_A, ($urandom_range(0, 6) == 0) ? $urandom_range(0, 9) : A_RDLEN);
        else if (roll < 60)
        begin
            str_len = $urandom_range(0, 12);
            add_text_record(str_len + 1 + $urandom_range(0, 3), str_len);
        end
        else if (roll < 70)
        begin
            // string may run past the rdata
            str_len = $urandom_range(0, 255);
            add_text_record($urandom_range(0, 6), str_len);
        end
        else if (roll < 85)
            add_record($urandom, $urandom_range(0, 10));
        else if (roll < 92)
            add_record(TYPE_A ^ (16'h1 << $urandom_range(0, 15)), $urandom_range(0, 6));
        else
            add_record(TYPE_TXT ^ (16'h1 << $urandom_range(0, 15)), $urandom_range(0, 6));
    endtask

    task random_reply();
        int          roll;
        int          answers;
        int          cut;
        logic [3:0]  rc;
        logic [15:0] count;
        roll = $urandom_range(0, 99);
        if (roll < 8 || offset_now > 150)
        begin
            frame.delete();
            push_random($urandom_range(1, 40));
        end
        else
        begin
            rc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 4'd0;
            answers = $urandom_range(0, 4);
            count = answers;
            if (roll < 14)
                count = answers + $urandom_range(1, 3);
            else if (roll < 16)
                count = $urandom;
            start_frame(rc, count);
            repeat (answers) random_record();
            push_random($urandom_range(0, 3));
            if (roll >= 88)
            begin
                cut = $urandom_range(1, frame.size());
                while (frame.size() > cut)
                    frame.delete(frame.size() - 1);
            end
        end
        send_frame();
    endtask

    initial
    begin
        byte_valid = 1'b0;
        byte_word  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_ANSWER_OFFSET;
        cfg_data   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // lone byte: short reply
        frame.delete();
        push_random(1);
        send_frame();

        // server error hides the answers
        start_frame(4'hF, 16'd2);
        add_name(NAME_POINTER);
        add_record(TYPE_A, A_RDLEN);
        add_name(NAME_POINTER);
        add_record(TYPE_A, A_RDLEN);
        send_frame();

        // A mode: good, odd-length, empty and foreign records
        start_frame(4'h0, 16'd5);
        add_name(NAME_POINTER);
        add_record(TYPE_A, A_RDLEN);
        add_name(NAME_LABELS);
        add_record(TYPE_A, A_RDLEN);
        add_name(NAME_LABELS_POINTER);
        add_record(TYPE_A, 16'd5);
        add_name(NAME_LABELS);
        add_text_record(16'd4, 8'd3);
        add_name(NAME_POINTER);
        add_record(16'hFFFF, 16'd0);
        send_frame();

        // answer count far above what arrives
        start_frame(4'h0, 16'hFFFF);
        add_name(NAME_POINTER);
        add_record(TYPE_A, A_RDLEN);
        send_frame();

        // offset inside the header: answers start right after the counts
        set_config('0, MODE_A);
        start_frame(4'h0, 16'd1);
        add_name(NAME_POINTER);
        add_record(TYPE_A, A_RDLEN);
        send_frame();

        // TXT mode strings: normal, cut by rdata, empty, bare length, no rdata
        set_config(OFFSET_AT_RESET, MODE_TXT);
        start_frame(4'h0, 16'd7);
        add_name(NAME_LABELS);
        add_text_record(16'd8, 8'd5);
        add_name(NAME_POINTER);
        add_text_record(16'd6, 8'd20);
        add_name(NAME_POINTER);
        add_text_record(16'd4, 8'hFF);
        add_name(NAME_ROOT);
        add_text_record(16'd3, 8'd0);
        add_name(NAME_POINTER);
        add_text_record(16'd1, 8'd7);
        add_name(NAME_POINTER);
        add_text_record(16'd0, 8'd0);
        add_name(NAME_LABELS);
        add_record(TYPE_A, A_RDLEN);
        send_frame();

        // offset beyond anything a reply can reach
        set_config('1, MODE_A);
        frame.delete();
        push_random(30);
        send_frame();

        // length bytes with reserved top bits, then an rdata with a nonzero
        // high length byte that runs past the receive limit
        set_config(OFFSET_AT_RESET, MODE_A);
        start_frame(4'h0, 16'd2);
        add_name(NAME_WIDE_LOW);
        add_record(TYPE_A, A_RDLEN);
        add_name(NAME_WIDE_HIGH);
        add_record(TYPE_TXT, 16'h0320);
        send_frame();

        set_config(pick_offset(), $urandom_range(0, 1));
        while (bytes_sent < TOTAL_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
                set_config(pick_offset(), $urandom_range(0, 1));
            random_reply();
        end

        wait_idle();
        if (fail_count == 0)
            $display("dns_answer_record_parser_unit_test passed");
        else
            $display("dns_answer_record_parser_unit_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/dnsp_pkg.sv
design/dnsp_parser.sv
design/dnsp_out_queue.sv
design/dns_answer_record_parser_unit.sv
tb/dns_answer_record_parser_unit_checker.sv
tb/dns_answer_record_parser_unit_test.sv
